@@ hw/rtl/tfpc_pkg.sv @@
// Shared types, codes and widths of the touch calibration and mapping block.
// No dependencies; imported by every module of the block.
package tfpc_pkg;

  // Width of configuration registers and raw readings.
  localparam int unsigned RegW = 12;
  // Width of the offset, span and multiplicand operand.
  localparam int unsigned OpAW = 16;
  // Width of the serial multiplier operand (one bit per cycle).
  localparam int unsigned OpBW = 12;
  // Width of a product and of a dividend.
  localparam int unsigned ProdW = OpAW + OpBW;
  // Default resolution of the touch controller.
  localparam int unsigned AdcBitsDefault = 12;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_CONTINUE = 3'd0,
    ST_CAL_OK   = 3'd1,
    ST_CAL_FAIL = 3'd2,
    ST_CONVERT  = 3'd3,
    ST_REJECT   = 3'd4
  } status_e;

  // Event commands.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_PRESS   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CONVERT = 2'd3
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TOL    = 3'd0,
    REG_LEFT   = 3'd1,
    REG_RIGHT  = 3'd2,
    REG_TOP    = 3'd3,
    REG_BOTTOM = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_e;

  // Operation of the shared serial arithmetic unit.
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_e;

  // Request to the serial arithmetic unit.
  typedef struct packed {
    logic start;
    op_e  op;
  } mdreq_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT,
    S_CHECK,
    S_M1,
    S_M2,
    S_ODIV,
    S_SPM,
    S_SPD,
    S_VM,
    S_VD
  } state_e;

endpackage

@@ hw/rtl/tfpc_muldiv.sv @@
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Depends on tfpc_pkg for widths and the request type.
module tfpc_muldiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tfpc_pkg::mdreq_t             req_i,
  input  logic [tfpc_pkg::OpAW-1:0]    a_i,
  input  logic [tfpc_pkg::OpBW-1:0]    b_i,
  input  logic [tfpc_pkg::ProdW-1:0]   n_i,
  input  logic [tfpc_pkg::OpAW-1:0]    c_i,
  output logic                         done_o,
  output logic [tfpc_pkg::ProdW-1:0]   res_o
);
  import tfpc_pkg::*;

  localparam int unsigned CntW = $clog2(ProdW + 1);

  logic [ProdW-1:0] acc_q, acc_d;
  logic [OpBW-1:0]  mb_q, mb_d;
  logic [OpAW-1:0]  ma_q, ma_d;
  logic [OpAW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  op_e              op_q, op_d;

  logic [OpAW:0]    rem_sh;
  logic [OpAW:0]    rem_sub;
  logic             fits;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  assign rem_sh  = {rem_q, acc_q[ProdW-1]};
  assign rem_sub = rem_sh - {1'b0, ma_q};
  assign fits    = rem_sh >= {1'b0, ma_q};

  always_comb begin
    acc_d  = acc_q;
    mb_d   = mb_q;
    ma_d   = ma_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      rem_d  = '0;
      mb_d   = b_i;
      if (req_i.op == OP_MUL) begin
        acc_d = '0;
        ma_d  = a_i;
        cnt_d = CntW'(OpBW);
      end else begin
        acc_d = n_i;
        ma_d  = c_i;
        cnt_d = CntW'(ProdW);
      end
    end else if (busy_q) begin
      // Multiply takes one multiplier bit per cycle, MSB first.
      if (op_q == OP_MUL) begin
        acc_d = {acc_q[ProdW-2:0], 1'b0} + (mb_q[OpBW-1] ? ProdW'(ma_q) : '0);
        mb_d  = {mb_q[OpBW-2:0], 1'b0};
      end else begin
        if (fits) begin
          rem_d = rem_sub[OpAW-1:0];
          acc_d = {acc_q[ProdW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[OpAW-1:0];
          acc_d = {acc_q[ProdW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mb_q  <= mb_d;
    ma_q  <= ma_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ hw/rtl/touch_four_point_calibrate_map_core.sv @@
// Touch calibration and raw-to-pixel mapping core: sequencer, state and output register.
// Depends on tfpc_pkg and tfpc_muldiv.
//
// The core takes one touch event at a time and returns one result item for it. The
// shared bit-serial unit works one bit per cycle. Start, press, release and rejected
// converts go straight to the emit state; a final release first passes the check
// state, and one that fails the checks then goes to emit. A convert that maps runs
// two multiplies and two divides. A final release that passes the checks solves
// both axes with up to three multiplies and two divides each. A stalled result holds
// the core in its emit state until the output register takes it. A new event is
// taken only when the previous one is done; configuration is written through a plain
// write port; the user must write it only while idle, the core does not enforce it.
module touch_four_point_calibrate_map_core #(
  parameter int unsigned ADC_BITS = tfpc_pkg::AdcBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [tfpc_pkg::RegW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  cmd_i,
  input  logic [tfpc_pkg::RegW-1:0]   raw_x_i,
  input  logic [tfpc_pkg::RegW-1:0]   raw_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [tfpc_pkg::RegW-1:0]   screen_x_o,
  output logic [tfpc_pkg::RegW-1:0]   screen_y_o,
  output logic                        is_calibrated_o
);
  import tfpc_pkg::*;

  localparam int unsigned MaskBits = (ADC_BITS > RegW) ? RegW : ADC_BITS;
  localparam logic [RegW-1:0] RawMask = RegW'((32'd1 << MaskBits) - 32'd1);

  // Configuration registers.
  logic [RegW-1:0] tol_q, left_q, right_q, top_q, bottom_q, width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= RegW'(50);
      left_q   <= RegW'(20);
      right_q  <= RegW'(300);
      top_q    <= RegW'(20);
      bottom_q <= RegW'(220);
      width_q  <= RegW'(320);
      height_q <= RegW'(240);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_TOL:    tol_q    <= cfg_wdata_i;
        REG_LEFT:   left_q   <= cfg_wdata_i;
        REG_RIGHT:  right_q  <= cfg_wdata_i;
        REG_TOP:    top_q    <= cfg_wdata_i;
        REG_BOTTOM: bottom_q <= cfg_wdata_i;
        REG_WIDTH:  width_q  <= cfg_wdata_i;
        REG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and calibration state.
  state_e           state_q, state_d;
  logic             first_q, first_d;
  logic             axis_q, axis_d;
  logic [3:0]       step_q, step_d;
  logic             cal_q, cal_d;
  logic [OpAW-1:0]  xoff_q, xoff_d, xspan_q, xspan_d, yoff_q, yoff_d, yspan_q, yspan_d;
  logic [RegW-1:0]  px_q [4];
  logic [RegW-1:0]  py_q [4];
  logic             pwe;
  logic [1:0]       pidx;
  logic [RegW-1:0]  rx_q, ry_q, rx_d, ry_d;
  logic [ProdW-1:0] t1_q, t1_d, num_q, num_d;
  status_e          rst_q, rst_d;
  logic [RegW-1:0]  rsx_q, rsx_d, rsy_q, rsy_d;
  logic             out_load;
  logic             accept;

  // Arithmetic unit link.
  mdreq_t           md_req;
  logic [OpAW-1:0]  md_a, md_c;
  logic [OpBW-1:0]  md_b;
  logic [ProdW-1:0] md_n, md_res;
  logic             md_done;

  tfpc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .a_i    (md_a),
    .b_i    (md_b),
    .n_i    (md_n),
    .c_i    (md_c),
    .done_o (md_done),
    .res_o  (md_res)
  );

  // Pair checks and averages of the stored corner readings.
  logic [RegW:0]   sxl, sxr, syt, syb;
  logic [RegW-1:0] xl, xr, yt, yb;
  logic [RegW-1:0] dx0, dx1, dy0, dy1;
  logic            pairs_ok, targets_ok;

  assign dx0 = (px_q[0] > px_q[2]) ? px_q[0] - px_q[2] : px_q[2] - px_q[0];
  assign dx1 = (px_q[1] > px_q[3]) ? px_q[1] - px_q[3] : px_q[3] - px_q[1];
  assign dy0 = (py_q[0] > py_q[1]) ? py_q[0] - py_q[1] : py_q[1] - py_q[0];
  assign dy1 = (py_q[2] > py_q[3]) ? py_q[2] - py_q[3] : py_q[3] - py_q[2];
  assign pairs_ok = (dx0 <= tol_q) && (dx1 <= tol_q) && (dy0 <= tol_q) && (dy1 <= tol_q);
  assign targets_ok = (right_q > left_q) && (left_q != '0) &&
                      (bottom_q > top_q) && (top_q != '0);

  assign sxl = {1'b0, px_q[0]} + {1'b0, px_q[2]};
  assign sxr = {1'b0, px_q[1]} + {1'b0, px_q[3]};
  assign syt = {1'b0, py_q[0]} + {1'b0, py_q[1]};
  assign syb = {1'b0, py_q[2]} + {1'b0, py_q[3]};
  assign xl  = sxl[RegW:1];
  assign xr  = sxr[RegW:1];
  assign yt  = syt[RegW:1];
  assign yb  = syb[RegW:1];

  // Per-axis operand selection.
  logic [RegW-1:0] a_lo, a_hi, a_plo, a_phi, a_size, a_raw;
  logic [OpAW-1:0] a_off, a_span, lo_ext;

  assign a_lo   = axis_q ? yt : xl;
  assign a_hi   = axis_q ? yb : xr;
  assign a_plo  = axis_q ? top_q : left_q;
  assign a_phi  = axis_q ? bottom_q : right_q;
  assign a_size = axis_q ? height_q : width_q;
  assign a_raw  = axis_q ? ry_q : rx_q;
  assign a_off  = axis_q ? yoff_q : xoff_q;
  assign a_span = axis_q ? yspan_q : xspan_q;
  assign lo_ext = OpAW'(a_lo);

  logic [OpAW-1:0] res_sat16;
  logic [RegW-1:0] res_sat12;
  assign res_sat16 = (md_res[ProdW-1:OpAW] != '0) ? '1 : md_res[OpAW-1:0];
  assign res_sat12 = (md_res[ProdW-1:RegW] != '0) ? '1 : md_res[RegW-1:0];

  logic [RegW-1:0] rxm, rym;
  assign rxm = raw_x_i & RawMask;
  assign rym = raw_y_i & RawMask;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // Next state, datapath updates and arithmetic requests.
  always_comb begin
    state_d  = state_q;
    axis_d   = axis_q;
    step_d   = step_q;
    cal_d    = cal_q;
    xoff_d   = xoff_q;
    xspan_d  = xspan_q;
    yoff_d   = yoff_q;
    yspan_d  = yspan_q;
    rx_d     = rx_q;
    ry_d     = ry_q;
    t1_d     = t1_q;
    num_d    = num_q;
    rst_d    = rst_q;
    rsx_d    = rsx_q;
    rsy_d    = rsy_q;
    pwe      = 1'b0;
    pidx     = step_q[2:1];
    out_load = 1'b0;
    md_req   = '{start: 1'b0, op: OP_MUL};
    md_a     = '0;
    md_b     = '0;
    md_n     = num_q;
    md_c     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rx_d    = rxm;
          ry_d    = rym;
          rst_d   = ST_CONTINUE;
          rsx_d   = '0;
          rsy_d   = '0;
          state_d = S_EMIT;
          unique case (cmd_e'(cmd_i))
            CMD_START: step_d = 4'd1;
            CMD_PRESS: begin
              if (step_q[0] && step_q <= 4'd7) begin
                pwe    = 1'b1;
                step_d = step_q + 4'd1;
              end
            end
            CMD_RELEASE: begin
              if (!step_q[0] && step_q >= 4'd2 && step_q <= 4'd6) begin
                step_d = step_q + 4'd1;
              end else if (step_q == 4'd8) begin
                step_d  = 4'd0;
                state_d = S_CHECK;
              end
            end
            CMD_CONVERT: begin
              if (OpAW'(rxm) <= xoff_q || xspan_q == '0 ||
                  OpAW'(rym) <= yoff_q || yspan_q == '0) begin
                rst_d = ST_REJECT;
              end else begin
                axis_d  = 1'b0;
                state_d = S_VM;
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (pairs_ok && targets_ok) begin
          axis_d  = 1'b0;
          state_d = S_M1;
        end else begin
          rst_d   = ST_CAL_FAIL;
          state_d = S_EMIT;
        end
      end
      // p_hi * lo
      S_M1: begin
        md_req = '{start: first_q, op: OP_MUL};
        md_a   = lo_ext;
        md_b   = OpBW'(a_phi);
        if (md_done) begin
          t1_d    = md_res;
          state_d = S_M2;
        end
      end
      // p_lo * hi, then the signed difference decides the offset path.
      S_M2: begin
        md_req = '{start: first_q, op: OP_MUL};
        md_a   = OpAW'(a_hi);
        md_b   = OpBW'(a_plo);
        if (md_done) begin
          if (md_res >= t1_q) begin
            if (axis_q) yoff_d = '0;
            else        xoff_d = '0;
            state_d = S_SPM;
          end else begin
            num_d   = t1_q - md_res;
            state_d = S_ODIV;
          end
        end
      end
      S_ODIV: begin
        md_req = '{start: first_q, op: OP_DIV};
        md_n   = num_q;
        md_c   = OpAW'(a_phi - a_plo);
        if (md_done) begin
          if (axis_q) yoff_d = res_sat16;
          else        xoff_d = res_sat16;
          state_d = S_SPM;
        end
      end
      // (lo - offset) * size, or a zero span when lo is not above the offset.
      S_SPM: begin
        md_a = lo_ext - a_off;
        md_b = OpBW'(a_size);
        if (lo_ext <= a_off) begin
          if (axis_q) yspan_d = '0;
          else        xspan_d = '0;
          if (axis_q) begin
            cal_d   = 1'b1;
            rst_d   = ST_CAL_OK;
            state_d = S_EMIT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_M1;
          end
        end else begin
          md_req = '{start: first_q, op: OP_MUL};
          if (md_done) begin
            num_d   = md_res;
            state_d = S_SPD;
          end
        end
      end
      S_SPD: begin
        md_req = '{start: first_q, op: OP_DIV};
        md_n   = num_q;
        md_c   = OpAW'(a_plo);
        if (md_done) begin
          if (axis_q) yspan_d = res_sat16;
          else        xspan_d = res_sat16;
          if (axis_q) begin
            cal_d   = 1'b1;
            rst_d   = ST_CAL_OK;
            state_d = S_EMIT;
          end else begin
            axis_d  = 1'b1;
            state_d = S_M1;
          end
        end
      end
      // Convert: (raw - offset) * size / span, saturated to 12 bits.
      S_VM: begin
        md_req = '{start: first_q, op: OP_MUL};
        md_a   = OpAW'(a_raw) - a_off;
        md_b   = OpBW'(a_size);
        if (md_done) begin
          num_d   = md_res;
          state_d = S_VD;
        end
      end
      S_VD: begin
        md_req = '{start: first_q, op: OP_DIV};
        md_n   = num_q;
        md_c   = a_span;
        if (md_done) begin
          if (axis_q) begin
            rsy_d   = res_sat12;
            rst_d   = ST_CONVERT;
            state_d = S_EMIT;
          end else begin
            rsx_d   = res_sat12;
            axis_d  = 1'b1;
            state_d = S_VM;
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_o || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign first_d = (state_d != state_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      first_q <= 1'b0;
      axis_q  <= 1'b0;
      step_q  <= 4'd0;
      cal_q   <= 1'b0;
      xoff_q  <= '1;
      xspan_q <= '0;
      yoff_q  <= '0;
      yspan_q <= '0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      cal_q   <= cal_d;
      xoff_q  <= xoff_d;
      xspan_q <= xspan_d;
      yoff_q  <= yoff_d;
      yspan_q <= yspan_d;
    end
  end

  // Corner readings and working registers.
  always_ff @(posedge clk_i) begin
    if (pwe) begin
      px_q[pidx] <= rxm;
      py_q[pidx] <= rym;
    end
    rx_q  <= rx_d;
    ry_q  <= ry_d;
    t1_q  <= t1_d;
    num_q <= num_d;
    rst_q <= rst_d;
    rsx_q <= rsx_d;
    rsy_q <= rsy_d;
  end

  // Output register.
  logic            ov_q;
  logic [2:0]      ost_q;
  logic [RegW-1:0] osx_q, osy_q;
  logic            ocal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ost_q  <= rst_q;
      osx_q  <= rsx_q;
      osy_q  <= rsy_q;
      ocal_q <= cal_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ost_q;
  assign screen_x_o      = osx_q;
  assign screen_y_o      = osy_q;
  assign is_calibrated_o = ocal_q;

endmodule

@@ hw/rtl/tfpc_checker.sv @@
// Port-level checks of the touch calibration core, bound to its top level.
// Depends on tfpc_pkg and touch_four_point_calibrate_map_core.
module tfpc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [2:0]                status_o,
  input logic [tfpc_pkg::RegW-1:0] screen_x_o,
  input logic [tfpc_pkg::RegW-1:0] screen_y_o,
  input logic                      is_calibrated_o
);
  import tfpc_pkg::*;

  // A result item held back by the receiver stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // One event at a time: the core is busy right after it takes an item.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while the previous one is in flight");

  // Pixels are zero unless the item is a conversion.
  a_pixels_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_CONVERT |-> screen_x_o == '0 && screen_y_o == '0)
    else $error("pixels set on a non-converted item");

  // A mapped point needs nonzero spans, which only a good calibration gives.
  a_conv_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CONVERT || status_o == ST_CAL_OK) |-> is_calibrated_o)
    else $error("conversion or success without calibration");

endmodule

bind touch_four_point_calibrate_map_core tfpc_checker u_tfpc_checker (.*);
